// ===== hw/rtl/pl_pkg.sv =====
`timescale 1ns / 1ps

package pl_pkg;

  // widths
  localparam int POS_BITS = 16;
  localparam int START_W  = 16;
  localparam int LEN_W    = 16;
  localparam int KIND_W   = 5;
  localparam int ERR_W    = 2;
  localparam int MARK_W   = 4;

  // result queue
  localparam int Q_DEPTH = 4;
  localparam int Q_PTR_W = $clog2(Q_DEPTH);
  localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

  // token kinds beyond the marks
  localparam logic [KIND_W-1:0] KIND_NUMBER  = KIND_W'(13);
  localparam logic [KIND_W-1:0] KIND_QUOTE   = KIND_W'(14);
  localparam logic [KIND_W-1:0] KIND_IDENT   = KIND_W'(15);
  localparam logic [KIND_W-1:0] KIND_UNKNOWN = KIND_W'(16);

  // error codes
  localparam logic [ERR_W-1:0] ERR_NONE  = ERR_W'(0);
  localparam logic [ERR_W-1:0] ERR_EMPTY = ERR_W'(1);
  localparam logic [ERR_W-1:0] ERR_OPEN  = ERR_W'(2);

  // characters
  localparam logic [7:0] CH_QUOTE  = 8'h27;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_NL     = 8'h0A;
  localparam logic [7:0] CH_SPACE  = 8'h20;

  localparam logic [LEN_W-1:0] LEN_MAX = '1;

  // one result word
  typedef struct packed {
    logic [KIND_W-1:0]  kind;
    logic [ERR_W-1:0]   err;
    logic [START_W-1:0] start;
    logic [LEN_W-1:0]   length;
    logic               last;
  } pl_word_t;

  // words handed from the scanner to the queue in one cycle
  typedef struct packed {
    logic [1:0] cnt;
    pl_word_t   w0;
    pl_word_t   w1;
  } pl_push_t;

  typedef struct packed {
    logic              hit;
    logic [MARK_W-1:0] idx;
  } pl_mark_t;

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= 8'h30) && (c <= 8'h39);
  endfunction

  function automatic logic is_ident(input logic [7:0] c);
    return ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A)) || (c == 8'h5F);
  endfunction

  function automatic logic is_sep(input logic [7:0] c);
    return (c == CH_TAB) || (c == CH_NL) || (c == CH_SPACE);
  endfunction

  // mark lookup in the order = . | , ? * + ( ) { } [ ]
  function automatic pl_mark_t mark_lookup(input logic [7:0] c);
    pl_mark_t m;
    m.hit = 1'b1;
    unique case (c)
      8'h3D: m.idx = MARK_W'(0);
      8'h2E: m.idx = MARK_W'(1);
      8'h7C: m.idx = MARK_W'(2);
      8'h2C: m.idx = MARK_W'(3);
      8'h3F: m.idx = MARK_W'(4);
      8'h2A: m.idx = MARK_W'(5);
      8'h2B: m.idx = MARK_W'(6);
      8'h28: m.idx = MARK_W'(7);
      8'h29: m.idx = MARK_W'(8);
      8'h7B: m.idx = MARK_W'(9);
      8'h7D: m.idx = MARK_W'(10);
      8'h5B: m.idx = MARK_W'(11);
      8'h5D: m.idx = MARK_W'(12);
      default: begin
        m.hit = 1'b0;
        m.idx = MARK_W'(0);
      end
    endcase
    return m;
  endfunction

endpackage

// ===== hw/rtl/pl_in_reg.sv =====
`timescale 1ns / 1ps

module pl_in_reg import pl_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       text_valid,
  output logic       text_stall,
  input  logic [7:0] text_byte,
  input  logic       end_of_text,
  input  logic       take,
  output logic       vld,
  output logic [7:0] byte_q,
  output logic       eot_q
);

  logic accept;

  // hold while a word sits here that the scanner cannot take
  assign text_stall = vld && !take;
  assign accept     = text_valid && !text_stall;

  // valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= 1'b0;
    end else if (accept) begin
      vld <= 1'b1;
    end else if (take) begin
      vld <= 1'b0;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (accept) begin
      byte_q <= text_byte;
      eot_q  <= end_of_text;
    end
  end

endmodule

// ===== hw/rtl/pl_scan.sv =====
`timescale 1ns / 1ps

module pl_scan import pl_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_vld,
  input  logic [7:0] in_byte,
  input  logic       in_eot,
  input  logic       room,
  output logic       take,
  output pl_push_t   push
);

  typedef enum logic [2:0] {
    M_IDLE,
    M_NUMBER,
    M_IDENT,
    M_QUOTE,
    M_ESCAPE
  } mode_t;

  mode_t                mode;
  mode_t                mode_next;
  logic [POS_BITS-1:0]  token_begin;
  logic [POS_BITS-1:0]  begin_next;
  logic [POS_BITS-1:0]  byte_position;
  logic [POS_BITS-1:0]  position_next;
  logic [LEN_W-1:0]     run_length;
  logic [LEN_W-1:0]     run_next;
  logic [LEN_W-1:0]     run_inc;
  logic                 fresh;
  logic                 stay;
  pl_mark_t             mk;
  pl_word_t             e1;
  pl_word_t             e2;
  pl_word_t             e3;
  logic                 e1_vld;
  logic                 e2_vld;
  logic                 e3_vld;
  pl_word_t             w0;
  pl_word_t             w1;
  logic [1:0]           cnt;

  assign take = in_vld && room;

  // mode update and token emission for one byte
  always_comb begin
    mode_next     = mode;
    begin_next    = token_begin;
    run_next      = run_length;
    position_next = byte_position + 1'b1;
    fresh         = 1'b0;
    stay          = 1'b0;
    e1            = '0;
    e2            = '0;
    e3            = '0;
    e1_vld        = 1'b0;
    e2_vld        = 1'b0;
    e3_vld        = 1'b0;
    run_inc       = (run_length == LEN_MAX) ? run_length : run_length + 1'b1;
    mk            = mark_lookup(in_byte);

    // open token
    unique case (mode)
      M_NUMBER, M_IDENT: begin
        stay = (mode == M_NUMBER) ? is_digit(in_byte) : is_ident(in_byte);
        if (stay) begin
          run_next = run_inc;
        end else begin
          e1_vld    = 1'b1;
          e1.kind   = (mode == M_NUMBER) ? KIND_NUMBER : KIND_IDENT;
          e1.err    = ERR_NONE;
          e1.start  = START_W'(token_begin);
          e1.length = run_length;
          mode_next = M_IDLE;
          fresh     = 1'b1;
        end
      end
      M_ESCAPE: begin
        run_next  = run_inc;
        mode_next = M_QUOTE;
      end
      M_QUOTE: begin
        run_next = run_inc;
        if (in_byte == CH_QUOTE) begin
          e1_vld    = 1'b1;
          e1.kind   = KIND_QUOTE;
          e1.err    = (run_inc <= LEN_W'(2)) ? ERR_EMPTY : ERR_NONE;
          e1.start  = START_W'(token_begin);
          e1.length = run_inc;
          mode_next = M_IDLE;
        end else if (in_byte == CH_BSLASH) begin
          mode_next = M_ESCAPE;
        end
      end
      default: begin
        mode_next = M_IDLE;
        fresh     = 1'b1;
      end
    endcase

    // byte that starts something new
    e2.err    = ERR_NONE;
    e2.start  = START_W'(byte_position);
    e2.length = LEN_W'(1);
    if (fresh && !is_sep(in_byte)) begin
      if (mk.hit) begin
        e2_vld  = 1'b1;
        e2.kind = KIND_W'(mk.idx);
      end else if (is_digit(in_byte)) begin
        mode_next  = M_NUMBER;
        begin_next = byte_position;
        run_next   = LEN_W'(1);
      end else if (in_byte == CH_QUOTE) begin
        mode_next  = M_QUOTE;
        begin_next = byte_position;
        run_next   = LEN_W'(1);
      end else if (is_ident(in_byte)) begin
        mode_next  = M_IDENT;
        begin_next = byte_position;
        run_next   = LEN_W'(1);
      end else begin
        e2_vld  = 1'b1;
        e2.kind = KIND_UNKNOWN;
      end
    end

    // flush at end of text
    e3.start  = START_W'(begin_next);
    e3.length = run_next;
    e3.err    = ERR_NONE;
    e3.kind   = (mode_next == M_NUMBER) ? KIND_NUMBER : KIND_IDENT;
    if (in_eot) begin
      if (mode_next == M_NUMBER || mode_next == M_IDENT) begin
        e3_vld = 1'b1;
      end else if (mode_next == M_QUOTE || mode_next == M_ESCAPE) begin
        e3_vld  = 1'b1;
        e3.kind = KIND_QUOTE;
        if (run_next <= LEN_W'(2)) begin
          e3.err = ERR_EMPTY;
        end else if (in_byte == CH_QUOTE) begin
          e3.err = ERR_NONE;
        end else begin
          e3.err = ERR_OPEN;
        end
      end
      mode_next     = M_IDLE;
      begin_next    = '0;
      run_next      = '0;
      position_next = '0;
    end

    // pack into at most two words, last flag on the final one
    w0  = e1_vld ? e1 : (e2_vld ? e2 : e3);
    w1  = e2_vld ? e2 : e3;
    cnt = 2'(e1_vld) + 2'(e2_vld) + 2'(e3_vld);
    if (cnt == 2'd2) begin
      w0.last = 1'b0;
      w1.last = 1'b1;
    end else begin
      w0.last = 1'b1;
      w1.last = 1'b0;
    end
  end

  assign push.cnt = take ? cnt : 2'd0;
  assign push.w0  = w0;
  assign push.w1  = w1;

  // scan state
  always_ff @(posedge clk) begin
    if (rst) begin
      mode          <= M_IDLE;
      token_begin   <= '0;
      byte_position <= '0;
      run_length    <= '0;
    end else if (take) begin
      mode          <= mode_next;
      token_begin   <= begin_next;
      byte_position <= position_next;
      run_length    <= run_next;
    end
  end

  // end of text returns to the start of a new text
  a_eot_restart: assert property (@(posedge clk) disable iff (rst)
    take && in_eot |=> byte_position == '0 && mode == M_IDLE)
    else $error("scan state not cleared after end of text");

  // an open token always holds at least one byte
  a_open_len: assert property (@(posedge clk) disable iff (rst)
    mode != M_IDLE |-> run_length != '0)
    else $error("open token with zero length");

  // a digit taken while idle opens a number
  a_digit_opens: assert property (@(posedge clk) disable iff (rst)
    take && !in_eot && mode == M_IDLE && is_digit(in_byte)
    |=> mode == M_NUMBER && run_length == LEN_W'(1))
    else $error("digit did not open a number");

endmodule

// ===== hw/rtl/pl_queue.sv =====
`timescale 1ns / 1ps

module pl_queue import pl_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  pl_push_t push,
  output logic     room,
  output logic     out_vld,
  input  logic     out_stall,
  output pl_word_t out_word
);

  pl_word_t           slots [Q_DEPTH];
  logic [Q_PTR_W-1:0] wr_ptr;
  logic [Q_PTR_W-1:0] rd_ptr;
  logic [Q_CNT_W-1:0] count;
  logic               pop;

  // space for the two words one byte can cause
  assign room     = count <= Q_CNT_W'(Q_DEPTH - 2);
  assign out_vld  = count != '0;
  assign out_word = slots[rd_ptr];
  assign pop      = out_vld && !out_stall;

  // storage
  always_ff @(posedge clk) begin
    if (push.cnt != 2'd0) begin
      slots[wr_ptr] <= push.w0;
    end
    if (push.cnt == 2'd2) begin
      slots[wr_ptr + 1'b1] <= push.w1;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + Q_PTR_W'(push.cnt);
      rd_ptr <= rd_ptr + Q_PTR_W'(pop);
      count  <= count + Q_CNT_W'(push.cnt) - Q_CNT_W'(pop);
    end
  end

  a_no_overfill: assert property (@(posedge clk) disable iff (rst)
    count <= Q_CNT_W'(Q_DEPTH))
    else $error("result queue overfilled");

  a_push_room: assert property (@(posedge clk) disable iff (rst)
    push.cnt != 2'd0 |-> room)
    else $error("push without room");

  a_hold_word: assert property (@(posedge clk) disable iff (rst)
    out_vld && out_stall |=> out_vld && $stable(out_word))
    else $error("stalled word changed");

endmodule

// ===== hw/rtl/pattern_lexer_top.sv =====
`timescale 1ns / 1ps

// pattern text lexer
// text channel: one byte per word (text_byte, end_of_text) on text_valid /
// text_stall; end_of_text marks the final byte and the next byte starts a
// new text at offset zero.
// token channel: one token per word (token_kind, error_code, token_start,
// token_length, last_result) on token_valid / token_stall; last_result
// flags the final token caused by a byte, a byte causes zero, one or two.
// path: a byte is held in the input register, the scanner writes its tokens
// into the result queue once the queue has room, and the queue presents
// them; a second token from the same byte follows the first from the queue.
// throughput: one byte per cycle while the queue has room, set by the
// scanner stage; bytes causing two tokens are limited by the token
// channel to one token per cycle, the four-word result queue absorbs short
// bursts. reset clears the scan mode, the offset counter and the result queue.
// while token_stall is high the presented token holds; once the queue has
// fewer than two free words text_stall rises and the byte in the input
// register holds.

module pattern_lexer_top import pl_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               text_valid,
  output logic               text_stall,
  input  logic [7:0]         text_byte,
  input  logic               end_of_text,
  output logic               token_valid,
  input  logic               token_stall,
  output logic [KIND_W-1:0]  token_kind,
  output logic [ERR_W-1:0]   error_code,
  output logic [START_W-1:0] token_start,
  output logic [LEN_W-1:0]   token_length,
  output logic               last_result
);

  logic       in_vld;
  logic [7:0] in_byte;
  logic       in_eot;
  logic       take;
  logic       room;
  pl_push_t   push;
  pl_word_t   out_word;

  pl_in_reg u_in_reg (
    .clk         (clk),
    .rst         (rst),
    .text_valid  (text_valid),
    .text_stall  (text_stall),
    .text_byte   (text_byte),
    .end_of_text (end_of_text),
    .take        (take),
    .vld         (in_vld),
    .byte_q      (in_byte),
    .eot_q       (in_eot)
  );

  pl_scan u_scan (
    .clk     (clk),
    .rst     (rst),
    .in_vld  (in_vld),
    .in_byte (in_byte),
    .in_eot  (in_eot),
    .room    (room),
    .take    (take),
    .push    (push)
  );

  pl_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .room      (room),
    .out_vld   (token_valid),
    .out_stall (token_stall),
    .out_word  (out_word)
  );

  assign token_kind   = out_word.kind;
  assign error_code   = out_word.err;
  assign token_start  = out_word.start;
  assign token_length = out_word.length;
  assign last_result  = out_word.last;

endmodule
